### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the sampler RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: assertion failed");

`endif

### rtl/kdrs_pkg.sv
// ----------------------------------------------------------------------------
// kdrs_pkg
// Shared constants, register indexes and controller/datapath types.
// ----------------------------------------------------------------------------
`default_nettype none

package kdrs_pkg;

	localparam int FIELD_W          = 32;
	localparam int LIMB_W           = 32;
	localparam int IDX_W            = 8;
	localparam int W_W              = FIELD_W + 1;
	localparam int ITERATIONS_DEF   = 32;
	localparam int RADIUS_WIDTH_DEF = 32;

	localparam logic [FIELD_W-1:0] SCALE_LENGTH_RST = 32'd50331648;
	localparam logic [FIELD_W-1:0] OUTER_RADIUS_RST = 32'd241591910;

	localparam logic [IDX_W-1:0] CFG_SCALE_LENGTH = 8'd0;
	localparam logic [IDX_W-1:0] CFG_OUTER_RADIUS = 8'd1;

	typedef enum logic [3:0] {
		DP_NOP,
		DP_MUL_WW,
		DP_MUL_AA,
		DP_MUL_RR_EDGE,
		DP_MUL_RR_MID,
		DP_MUL_WS,
		DP_MID,
		DP_NARROW,
		DP_EMIT_EDGE,
		DP_EMIT_MID
	} dp_op_t;

	typedef struct packed {
		logic   take;
		dp_op_t op;
	} dp_cmd_t;

	typedef struct packed {
		logic mul_done;
		logic lt;
		logic eq;
	} dp_sts_t;

endpackage

`default_nettype wire

### rtl/kdrs_smp_if.sv
// ----------------------------------------------------------------------------
// kdrs_smp_if
// Sample channel: one uniform fraction per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface kdrs_smp_if;
	logic                         valid;
	logic                         ready;
	logic [kdrs_pkg::FIELD_W-1:0] random_fraction;

	modport source (output valid, output random_fraction, input ready);
	modport sink   (input valid, input random_fraction, output ready);
endinterface

`default_nettype wire

### rtl/kdrs_res_if.sv
// ----------------------------------------------------------------------------
// kdrs_res_if
// Result channel: radius and beyond-edge flag per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface kdrs_res_if;
	logic                         valid;
	logic                         ready;
	logic [kdrs_pkg::FIELD_W-1:0] radius;
	logic                         beyond_edge;

	modport source (output valid, output radius, output beyond_edge, input ready);
	modport sink   (input valid, input radius, input beyond_edge, output ready);
endinterface

`default_nettype wire

### rtl/kdrs_cfg_if.sv
// ----------------------------------------------------------------------------
// kdrs_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
`default_nettype none

interface kdrs_cfg_if;
	logic                         valid;
	logic                         ready;
	logic [kdrs_pkg::IDX_W-1:0]   index;
	logic [kdrs_pkg::FIELD_W-1:0] wdata;

	modport source (output valid, output index, output wdata, input ready);
	modport sink   (input valid, input index, input wdata, output ready);
endinterface

`default_nettype wire

### rtl/kdrs_mul.sv
// ----------------------------------------------------------------------------
// kdrs_mul
// Limb-serial multiplier: one 32x32 partial product per cycle, accumulated
// into a wide register. Operands must hold until done.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module kdrs_mul #(
	parameter int NL = 3,
	parameter int PW = 130
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	input  wire logic [$clog2(NL):0]             na,
	input  wire logic [$clog2(NL):0]             nb,
	input  wire logic [NL*kdrs_pkg::LIMB_W-1:0]  op_a,
	input  wire logic [NL*kdrs_pkg::LIMB_W-1:0]  op_b,
	output logic                                 done,
	output logic [PW-1:0]                        prod
);
	import kdrs_pkg::*;

	localparam int IB   = $clog2(NL);
	localparam int CNTW = IB + 1;

	logic                  issue_q;
	logic [IB-1:0]         i_q;
	logic [IB-1:0]         j_q;
	logic                  pv_s1;
	logic                  last_s1;
	logic [CNTW-1:0]       sh_s1;
	logic [2*LIMB_W-1:0]   prod_s1;
	logic [PW-1:0]         acc_q;
	logic                  done_q;
	logic [LIMB_W-1:0]     a_limb;
	logic [LIMB_W-1:0]     b_limb;
	logic                  i_last;
	logic                  j_last;
	logic [PW-1:0]         addend;

	assign a_limb = op_a[LIMB_W*i_q +: LIMB_W];
	assign b_limb = op_b[LIMB_W*j_q +: LIMB_W];
	assign i_last = (CNTW'(i_q) == na - CNTW'(1));
	assign j_last = (CNTW'(j_q) == nb - CNTW'(1));
	assign addend = PW'(prod_s1) << (LIMB_W * sh_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_q <= 1'b0;
			i_q     <= '0;
			j_q     <= '0;
			pv_s1   <= 1'b0;
			last_s1 <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			pv_s1   <= issue_q;
			last_s1 <= issue_q && i_last && j_last;
			done_q  <= pv_s1 && last_s1;
			if (start) begin
				issue_q <= 1'b1;
				i_q     <= '0;
				j_q     <= '0;
			end else if (issue_q) begin
				if (j_last) begin
					j_q <= '0;
					if (i_last) begin
						issue_q <= 1'b0;
					end else begin
						i_q <= i_q + IB'(1);
					end
				end else begin
					j_q <= j_q + IB'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= a_limb * b_limb;
		sh_s1   <= CNTW'(i_q) + CNTW'(j_q);
		if (start) begin
			acc_q <= '0;
		end else if (pv_s1) begin
			acc_q <= acc_q + addend;
		end
	end

	assign done = done_q;
	assign prod = acc_q;

	`ASSERT_IMPL(a_start_when_free, clk, arst_n, start, !issue_q && !pv_s1)
	`ASSERT_NEXT(a_done_single, clk, arst_n, done_q, !done_q)

endmodule

`default_nettype wire

### rtl/kdrs_dp.sv
// ----------------------------------------------------------------------------
// kdrs_dp
// Datapath: search bounds, midpoint, squared terms, exact test of
// w^2*(r^2+a^2) against a^2*2^64, and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module kdrs_dp #(
	parameter int RADIUS_WIDTH = kdrs_pkg::RADIUS_WIDTH_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire kdrs_pkg::dp_cmd_t            cmd,
	output kdrs_pkg::dp_sts_t                 sts,
	input  wire logic [kdrs_pkg::FIELD_W-1:0] random_fraction,
	input  wire logic [kdrs_pkg::FIELD_W-1:0] scale_length,
	input  wire logic [kdrs_pkg::FIELD_W-1:0] outer_radius,
	output logic [kdrs_pkg::FIELD_W-1:0]      radius,
	output logic                              beyond_edge
);
	import kdrs_pkg::*;

	localparam int RW       = RADIUS_WIDTH;
	localparam int FRAC     = RW - 8;
	localparam int SHIFT_UP = (FRAC >= 24) ? FRAC - 24 : 0;
	localparam int SHIFT_DN = (FRAC < 24) ? 24 - FRAC : 0;
	localparam int CW       = FIELD_W + SHIFT_UP;
	localparam int SQ_W     = 2 * CW;
	localparam int SUM_W    = SQ_W + 1;
	localparam int WSQ_W    = 2 * W_W - 1;
	localparam int NL       = (SUM_W + LIMB_W - 1) / LIMB_W;
	localparam int LW       = NL * LIMB_W;
	localparam int PW       = SQ_W + 2 * W_W;
	localparam int CNTW     = $clog2(NL) + 1;
	localparam int NW       = (W_W + LIMB_W - 1) / LIMB_W;
	localparam int NQ       = (WSQ_W + LIMB_W - 1) / LIMB_W;
	localparam int NC       = (CW + LIMB_W - 1) / LIMB_W;

	dp_op_t            mul_op_q;
	logic [W_W-1:0]    w_q;
	logic [WSQ_W-1:0]  wsq_q;
	logic [SQ_W-1:0]   asq_q;
	logic [SUM_W-1:0]  sum_q;
	logic [RW-1:0]     lo_q;
	logic [RW-1:0]     hi_q;
	logic [RW-1:0]     mid_q;
	logic              lt_q;
	logic              eq_q;
	logic [FIELD_W-1:0] radius_q;
	logic              edge_q;

	logic              mul_start;
	logic              mul_done;
	logic [PW-1:0]     acc;
	logic [LW-1:0]     op_a;
	logic [LW-1:0]     op_b;
	logic [CNTW-1:0]   na;
	logic [CNTW-1:0]   nb;
	logic [CW-1:0]     a_common;
	logic [CW-1:0]     m_common;
	logic [CW-1:0]     mid_common;
	logic [RW-1:0]     hi_init;
	logic [RW:0]       bound_sum;
	logic [CW-1:0]     res_full;
	logic [PW-1:0]     rhs;

	assign a_common   = CW'(scale_length) << SHIFT_UP;
	assign m_common   = CW'(outer_radius) << SHIFT_UP;
	assign mid_common = CW'(mid_q) << SHIFT_DN;
	assign hi_init    = RW'(m_common >> SHIFT_DN);
	assign bound_sum  = {1'b0, lo_q} + {1'b0, hi_q};
	assign res_full   = (CW'(mid_q) >> SHIFT_UP) << SHIFT_DN;
	assign rhs        = PW'({asq_q, {(2*FIELD_W){1'b0}}});

	always_comb begin
		unique case (cmd.op) inside
			DP_MUL_WW, DP_MUL_AA, DP_MUL_RR_EDGE, DP_MUL_RR_MID, DP_MUL_WS: begin
				mul_start = 1'b1;
			end
			default: begin
				mul_start = 1'b0;
			end
		endcase
	end

	always_comb begin
		op_a = '0;
		op_b = '0;
		na   = CNTW'(1);
		nb   = CNTW'(1);
		case (mul_op_q)
			DP_MUL_WW: begin
				op_a = LW'(w_q);
				op_b = LW'(w_q);
				na   = CNTW'(NW);
				nb   = CNTW'(NW);
			end
			DP_MUL_AA: begin
				op_a = LW'(a_common);
				op_b = LW'(a_common);
				na   = CNTW'(NC);
				nb   = CNTW'(NC);
			end
			DP_MUL_RR_EDGE: begin
				op_a = LW'(m_common);
				op_b = LW'(m_common);
				na   = CNTW'(NC);
				nb   = CNTW'(NC);
			end
			DP_MUL_RR_MID: begin
				op_a = LW'(mid_common);
				op_b = LW'(mid_common);
				na   = CNTW'(NC);
				nb   = CNTW'(NC);
			end
			DP_MUL_WS: begin
				op_a = LW'(wsq_q);
				op_b = LW'(sum_q);
				na   = CNTW'(NQ);
				nb   = CNTW'(NL);
			end
			default: begin
				op_a = '0;
			end
		endcase
	end

	kdrs_mul #(
		.NL (NL),
		.PW (PW)
	) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.na     (na),
		.nb     (nb),
		.op_a   (op_a),
		.op_b   (op_b),
		.done   (mul_done),
		.prod   (acc)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mul_op_q <= DP_NOP;
		end else if (mul_start) begin
			mul_op_q <= cmd.op;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			w_q  <= {1'b1, {FIELD_W{1'b0}}} - {1'b0, random_fraction};
			lo_q <= '0;
			hi_q <= hi_init;
		end
		case (cmd.op)
			DP_MID: begin
				mid_q <= bound_sum[RW:1];
			end
			DP_NARROW: begin
				if (lt_q) begin
					lo_q <= mid_q;
				end else begin
					hi_q <= mid_q;
				end
			end
			DP_EMIT_EDGE: begin
				radius_q <= outer_radius;
				edge_q   <= 1'b1;
			end
			DP_EMIT_MID: begin
				radius_q <= res_full[FIELD_W-1:0];
				edge_q   <= 1'b0;
			end
			default: begin
			end
		endcase
		if (mul_done) begin
			case (mul_op_q) inside
				DP_MUL_WW: begin
					wsq_q <= acc[WSQ_W-1:0];
				end
				DP_MUL_AA: begin
					asq_q <= acc[SQ_W-1:0];
				end
				DP_MUL_RR_EDGE, DP_MUL_RR_MID: begin
					sum_q <= {1'b0, acc[SQ_W-1:0]} + {1'b0, asq_q};
				end
				DP_MUL_WS: begin
					lt_q <= (acc < rhs);
					eq_q <= (acc == rhs);
				end
				default: begin
				end
			endcase
		end
	end

	assign sts.mul_done = mul_done;
	assign sts.lt       = lt_q;
	assign sts.eq       = eq_q;
	assign radius       = radius_q;
	assign beyond_edge  = edge_q;

endmodule

`default_nettype wire

### rtl/kdrs_ctrl.sv
// ----------------------------------------------------------------------------
// kdrs_ctrl
// Controller: sequences setup products, the edge test, the bisection steps
// and the result handoff.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module kdrs_ctrl #(
	parameter int ITERATIONS = kdrs_pkg::ITERATIONS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              smp_valid,
	output logic                   smp_ready,
	output logic                   res_valid,
	input  wire logic              res_ready,
	output kdrs_pkg::dp_cmd_t      cmd,
	input  wire kdrs_pkg::dp_sts_t sts
);
	import kdrs_pkg::*;

	localparam int ITW = $clog2(ITERATIONS);

	typedef enum logic [3:0] {
		S_IDLE,
		S_WAIT_WW,
		S_WAIT_AA,
		S_WAIT_RR,
		S_WAIT_WS,
		S_EVAL,
		S_NEXT,
		S_SQ,
		S_FIN,
		S_OUT,
		S_EMIT
	} state_t;

	state_t         state_q;
	logic           ready_q;
	logic           res_valid_q;
	dp_op_t         op_q;
	logic           edge_q;
	logic           out_edge_q;
	logic [ITW-1:0] it_q;

	assign cmd.take  = smp_valid && ready_q;
	assign cmd.op    = op_q;
	assign smp_ready = ready_q;
	assign res_valid = res_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ready_q     <= 1'b1;
			res_valid_q <= 1'b0;
			op_q        <= DP_NOP;
			edge_q      <= 1'b0;
			out_edge_q  <= 1'b0;
			it_q        <= '0;
		end else begin
			op_q <= DP_NOP;
			if (res_valid_q && res_ready) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (smp_valid && ready_q) begin
						ready_q <= 1'b0;
						op_q    <= DP_MUL_WW;
						state_q <= S_WAIT_WW;
					end
				end
				S_WAIT_WW: begin
					if (sts.mul_done) begin
						op_q    <= DP_MUL_AA;
						state_q <= S_WAIT_AA;
					end
				end
				S_WAIT_AA: begin
					if (sts.mul_done) begin
						op_q    <= DP_MUL_RR_EDGE;
						edge_q  <= 1'b1;
						state_q <= S_WAIT_RR;
					end
				end
				S_WAIT_RR: begin
					if (sts.mul_done) begin
						op_q    <= DP_MUL_WS;
						state_q <= S_WAIT_WS;
					end
				end
				S_WAIT_WS: begin
					if (sts.mul_done) begin
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					if (edge_q) begin
						if (sts.lt || sts.eq) begin
							out_edge_q <= 1'b1;
							state_q    <= S_OUT;
						end else begin
							edge_q  <= 1'b0;
							it_q    <= '0;
							op_q    <= DP_MID;
							state_q <= S_SQ;
						end
					end else if (sts.eq) begin
						out_edge_q <= 1'b0;
						state_q    <= S_OUT;
					end else begin
						op_q <= DP_NARROW;
						if (it_q == ITW'(ITERATIONS - 1)) begin
							state_q <= S_FIN;
						end else begin
							it_q    <= it_q + ITW'(1);
							state_q <= S_NEXT;
						end
					end
				end
				S_NEXT: begin
					op_q    <= DP_MID;
					state_q <= S_SQ;
				end
				S_SQ: begin
					op_q    <= DP_MUL_RR_MID;
					state_q <= S_WAIT_RR;
				end
				S_FIN: begin
					op_q       <= DP_MID;
					out_edge_q <= 1'b0;
					state_q    <= S_OUT;
				end
				S_OUT: begin
					if (!res_valid_q) begin
						op_q    <= out_edge_q ? DP_EMIT_EDGE : DP_EMIT_MID;
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					res_valid_q <= 1'b1;
					ready_q     <= 1'b1;
					state_q     <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`ASSERT_IMPL(a_ready_in_idle, clk, arst_n, ready_q, state_q == S_IDLE)
	`ASSERT_IMPL(a_valid_from_emit, clk, arst_n, $rose(res_valid_q), $past(state_q) == S_EMIT)
	`ASSERT_IMPL(a_done_while_waiting, clk, arst_n, sts.mul_done, state_q == S_WAIT_WW || state_q == S_WAIT_AA || state_q == S_WAIT_RR || state_q == S_WAIT_WS)

endmodule

`default_nettype wire

### rtl/disk_radius_bisection_sampler.sv
// ----------------------------------------------------------------------------
// disk_radius_bisection_sampler
// Kuzmin disk radius from a uniform fraction by exact bisection.
// ----------------------------------------------------------------------------
// Usage:
//   sample : one Q0.32 fraction per transfer (valid/ready).
//   result : radius (Q8.24) and beyond_edge per transfer; exactly one result
//            per sample, in order.
//   cfg    : writes index 0 (scale_length) or 1 (outer radius);
//            other indexes are dropped. Write only while idle.
// Operation: one item at a time. All products go through one 32x32 multiplier,
//   one partial product per cycle. A full search runs ITERATIONS bisection
//   steps; an exact hit ends early, a beyond-edge sample finishes after the
//   edge test.
// Reset: registers return to their defaults (3.0 and about 14.4), nothing
//   in flight, sample ready.
// Stall: a finished result sits in the output register; the next sample is
//   still taken and worked on, and its result waits until the register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module disk_radius_bisection_sampler #(
	parameter int ITERATIONS   = kdrs_pkg::ITERATIONS_DEF,
	parameter int RADIUS_WIDTH = kdrs_pkg::RADIUS_WIDTH_DEF
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	kdrs_smp_if.sink    sample,
	kdrs_res_if.source  result,
	kdrs_cfg_if.sink    cfg
);
	import kdrs_pkg::*;

	logic [FIELD_W-1:0] scale_length_q;
	logic [FIELD_W-1:0] outer_radius_q;
	dp_cmd_t            cmd;
	dp_sts_t            sts;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_length_q <= SCALE_LENGTH_RST;
			outer_radius_q <= OUTER_RADIUS_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_SCALE_LENGTH: begin
					scale_length_q <= cfg.wdata;
				end
				CFG_OUTER_RADIUS: begin
					outer_radius_q <= cfg.wdata;
				end
				default: begin
				end
			endcase
		end
	end

	kdrs_ctrl #(
		.ITERATIONS (ITERATIONS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.smp_valid (sample.valid),
		.smp_ready (sample.ready),
		.res_valid (result.valid),
		.res_ready (result.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	kdrs_dp #(
		.RADIUS_WIDTH (RADIUS_WIDTH)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.random_fraction (sample.random_fraction),
		.scale_length    (scale_length_q),
		.outer_radius    (outer_radius_q),
		.radius          (result.radius),
		.beyond_edge     (result.beyond_edge)
	);

endmodule

`default_nettype wire
